@@ sv/scsa_pkg.sv @@
// Shared types, status codes and size-class tables for the slab allocator.
// No dependencies; every file of the block but scsa_ram imports this package.
`timescale 1ns / 1ps
package scsa_pkg;

    localparam int unsigned PAGE_W   = 6;
    localparam int unsigned SLOT_W   = 7;
    localparam int unsigned CLASS_W  = 3;
    localparam int unsigned POOL_PAGES  = 64;
    localparam int unsigned CLASS_COUNT = 7;

    // Block area starts at the 48-byte header rounded up to 16.
    localparam logic [11:0] AREA_START = 12'd48;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_SIZE    = 4'd1;
    localparam logic [3:0] ST_NO_PAGES    = 4'd2;
    localparam logic [3:0] ST_NULL        = 4'd3;
    localparam logic [3:0] ST_OUT_RANGE   = 4'd4;
    localparam logic [3:0] ST_NOT_HEAP    = 4'd5;
    localparam logic [3:0] ST_OUT_BLOCKS  = 4'd6;
    localparam logic [3:0] ST_INTERIOR    = 4'd7;
    localparam logic [3:0] ST_INDEX_RANGE = 4'd8;
    localparam logic [3:0] ST_DOUBLE_FREE = 4'd9;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic               is_free;
        logic               err_valid;
        logic [3:0]         err;
        logic               area_bad;
        logic [CLASS_W-1:0] cls;
        logic [PAGE_W-1:0]  page;
        logic [11:0]        rel;
    } cmd_t;

    // Per-page bookkeeping: class, free count and stack low-water mark.
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  count;
        logic [SLOT_W-1:0]  lw;
    } meta_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_APEEK,
        S_APOP,
        S_FCHECK,
        S_FTAKEN
    } state_t;

    function automatic logic [11:0] class_bytes(input logic [CLASS_W-1:0] c);
        class_bytes = 12'd32 << c;
    endfunction

    // Blocks that fit behind the header, capped at the slot count.
    function automatic logic [SLOT_W-1:0] class_blocks(input logic [CLASS_W-1:0] c);
        case (c)
            3'd0:    class_blocks = 7'd126;
            3'd1:    class_blocks = 7'd63;
            3'd2:    class_blocks = 7'd31;
            3'd3:    class_blocks = 7'd15;
            3'd4:    class_blocks = 7'd7;
            3'd5:    class_blocks = 7'd3;
            3'd6:    class_blocks = 7'd1;
            default: class_blocks = 7'd126;
        endcase
    endfunction

    // Free bytes a fresh page adds once its first block is handed out.
    function automatic logic [11:0] class_net_bytes(input logic [CLASS_W-1:0] c);
        case (c)
            3'd0:    class_net_bytes = 12'd4000;
            3'd1:    class_net_bytes = 12'd3968;
            3'd2:    class_net_bytes = 12'd3840;
            3'd3:    class_net_bytes = 12'd3584;
            3'd4:    class_net_bytes = 12'd3072;
            3'd5:    class_net_bytes = 12'd2048;
            3'd6:    class_net_bytes = 12'd0;
            default: class_net_bytes = 12'd0;
        endcase
    endfunction

endpackage

@@ sv/scsa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module scsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/scsa_front.sv @@
// Front end: accepts items and classifies them into commands.
// Depends on scsa_pkg.
`timescale 1ns / 1ps
module scsa_front import scsa_pkg::*; (
    input  logic        start,
    input  logic        full,
    input  logic        operation,
    input  logic [15:0] request_size,
    input  logic        is_null,
    input  logic [7:0]  free_page,
    input  logic [11:0] free_offset,
    output logic        push,
    output cmd_t        cmd
);

    assign push = start && !full;

    // Size-class lookup and the checks that need no heap state.
    always_comb
    begin
        logic found;
        cmd   = '0;
        found = 1'b0;
        cmd.is_free = operation;
        for (int i = CLASS_COUNT - 1; i >= 0; i--)
        begin
            if (request_size <= 16'(class_bytes(CLASS_W'(i))))
            begin
                cmd.cls = CLASS_W'(i);
                found   = 1'b1;
            end
        end
        cmd.page     = free_page[PAGE_W-1:0];
        cmd.rel      = free_offset - AREA_START;
        cmd.area_bad = free_offset < AREA_START;
        if (!operation)
        begin
            if (request_size == 16'd0 || !found)
            begin
                cmd.err_valid = 1'b1;
                cmd.err       = ST_BAD_SIZE;
            end
        end
        else if (is_null)
        begin
            cmd.err_valid = 1'b1;
            cmd.err       = ST_NULL;
        end
        else if (free_page >= 8'(POOL_PAGES))
        begin
            cmd.err_valid = 1'b1;
            cmd.err       = ST_OUT_RANGE;
        end
    end

endmodule

@@ sv/scsa_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on scsa_pkg.
`timescale 1ns / 1ps
module scsa_queue import scsa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output cmd_t cmd_out,
    output logic empty,
    output logic full
);

    cmd_t       entry_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty   = count_reg == 2'd0;
    assign full    = count_reg == 2'd2;
    assign cmd_out = entry_reg[rptr_reg];

    // Pointer and occupancy updates.
    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

@@ sv/scsa_back.sv @@
// Back end: carries out allocate and free commands against the page tables.
// Depends on scsa_pkg and scsa_ram.
`timescale 1ns / 1ps
module scsa_back import scsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [6:0]  limit,
    input  cmd_t        cmd,
    input  logic        empty,
    output logic        pop,
    output logic        done,
    output logic [3:0]  status,
    output logic [5:0]  page_number,
    output logic [11:0] block_offset,
    output logic [11:0] block_bytes,
    output logic [6:0]  pages_in_use,
    output logic [17:0] free_bytes,
    output logic [17:0] allocated_bytes
);

    localparam int unsigned ADDR_W = PAGE_W + SLOT_W;

    state_t state_reg;
    state_t state_next;

    cmd_t              cmd_reg;
    logic [PAGE_W-1:0] pg_reg;
    logic [PAGE_W-1:0] pg_next;
    meta_t             meta_reg;
    meta_t             meta_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              direct_reg;
    logic              direct_next;
    logic [6:0]        used_reg;
    logic [6:0]        used_next;
    logic [17:0]       free_tot_reg;
    logic [17:0]       free_tot_next;
    logic [17:0]       taken_tot_reg;
    logic [17:0]       taken_tot_next;
    logic [POOL_PAGES-1:0] avail_reg [CLASS_COUNT];

    logic              done_reg;
    logic              done_next;
    logic [3:0]        status_reg;
    logic [3:0]        status_next;
    logic [5:0]        page_reg;
    logic [5:0]        page_next;
    logic [11:0]       offset_reg;
    logic [11:0]       offset_next;
    logic [11:0]       size_reg;
    logic [11:0]       size_next;

    logic               avail_we;
    logic               avail_val;
    logic [CLASS_W-1:0] avail_cls;
    logic [PAGE_W-1:0]  avail_pg;

    logic              meta_we;
    logic [PAGE_W-1:0] meta_waddr;
    meta_t             meta_wdata;
    logic [PAGE_W-1:0] meta_raddr;
    meta_t             meta_q;
    logic              stack_we;
    logic [ADDR_W-1:0] stack_waddr;
    logic [SLOT_W-1:0] stack_wdata;
    logic [ADDR_W-1:0] stack_raddr;
    logic [SLOT_W-1:0] stack_q;
    logic              taken_we;
    logic [ADDR_W-1:0] taken_waddr;
    logic              taken_wdata;
    logic [ADDR_W-1:0] taken_raddr;
    logic              taken_q;

    logic [POOL_PAGES-1:0] sel_mask;
    logic                  found;
    logic [PAGE_W-1:0]     found_pg;
    logic [6:0]            eff_limit;
    logic                  room;
    logic [CLASS_W-1:0]    f_cls;
    logic [11:0]           f_bsz;
    logic                  misaligned;
    logic [SLOT_W-1:0]     f_idx;
    logic [SLOT_W-1:0]     top;
    logic [SLOT_W-1:0]     a_idx;
    logic                  taken_bit;
    logic [11:0]           a_bsz;

    scsa_ram #(.WIDTH($bits(meta_t)), .DEPTH(POOL_PAGES)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_q)
    );

    scsa_ram #(.WIDTH(SLOT_W), .DEPTH(1 << ADDR_W)) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_q)
    );

    scsa_ram #(.WIDTH(1), .DEPTH(1 << ADDR_W)) u_taken (
        .clk   (clk),
        .we    (taken_we),
        .waddr (taken_waddr),
        .wdata (taken_wdata),
        .raddr (taken_raddr),
        .rdata (taken_q)
    );

    // Newest page of the class that still has a free block.
    always_comb
    begin
        sel_mask = avail_reg[cmd_reg.cls];
        found    = |sel_mask;
        found_pg = '0;
        for (int i = 0; i < POOL_PAGES; i++)
        begin
            if (sel_mask[i])
            begin
                found_pg = PAGE_W'(i);
            end
        end
    end

    // Decisions shared by the state and output logic.
    always_comb
    begin
        eff_limit  = (limit > 7'(POOL_PAGES)) ? 7'(POOL_PAGES) : limit;
        room       = used_reg < eff_limit;
        f_cls      = (meta_q.cls >= CLASS_W'(CLASS_COUNT)) ? '0 : meta_q.cls;
        f_bsz      = class_bytes(f_cls);
        misaligned = (cmd_reg.rel & (f_bsz - 12'd1)) != 12'd0;
        f_idx      = SLOT_W'(cmd_reg.rel >> ({1'b0, f_cls} + 4'd5));
        top        = meta_q.count - 7'd1;
        a_idx      = direct_reg ? idx_reg : stack_q;
        // Blocks below the low-water mark were never handed out.
        taken_bit  = (idx_reg >= meta_reg.lw) ? taken_q : 1'b0;
        a_bsz      = class_bytes(cmd_reg.cls);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (cmd_reg.err_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (!cmd_reg.is_free)
                begin
                    state_next = found ? S_APEEK : S_IDLE;
                end
                else if ({1'b0, cmd_reg.page} >= used_reg || cmd_reg.area_bad)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FCHECK;
                end
            end
            S_APEEK:
            begin
                state_next = S_APOP;
            end
            S_FCHECK:
            begin
                if (misaligned || f_idx >= class_blocks(f_cls))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FTAKEN;
                end
            end
            S_APOP:
            begin
                state_next = S_IDLE;
            end
            S_FTAKEN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs, memory accesses and bookkeeping updates.
    always_comb
    begin
        pop            = 1'b0;
        pg_next        = pg_reg;
        meta_next      = meta_reg;
        idx_next       = idx_reg;
        direct_next    = direct_reg;
        used_next      = used_reg;
        free_tot_next  = free_tot_reg;
        taken_tot_next = taken_tot_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        page_next      = page_reg;
        offset_next    = offset_reg;
        size_next      = size_reg;
        avail_we       = 1'b0;
        avail_val      = 1'b0;
        avail_cls      = cmd_reg.cls;
        avail_pg       = pg_reg;
        meta_we        = 1'b0;
        meta_waddr     = pg_reg;
        meta_wdata     = meta_reg;
        meta_raddr     = pg_reg;
        stack_we       = 1'b0;
        stack_waddr    = {pg_reg, meta_reg.count};
        stack_wdata    = idx_reg;
        stack_raddr    = {pg_reg, top};
        taken_we       = 1'b0;
        taken_waddr    = {pg_reg, idx_reg};
        taken_wdata    = 1'b0;
        taken_raddr    = {pg_reg, f_idx};
        case (state_reg)
            S_IDLE:
            begin
                pop = !empty;
            end
            S_DISPATCH:
            begin
                if (cmd_reg.err_valid)
                begin
                    done_next   = 1'b1;
                    status_next = cmd_reg.err;
                    page_next   = '0;
                    offset_next = '0;
                    size_next   = '0;
                end
                else if (!cmd_reg.is_free)
                begin
                    if (found)
                    begin
                        pg_next    = found_pg;
                        meta_raddr = found_pg;
                    end
                    else if (!room)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NO_PAGES;
                        page_next   = '0;
                        offset_next = '0;
                        size_next   = '0;
                    end
                    else
                    begin
                        // Fresh page: its first block is the highest index.
                        meta_we          = 1'b1;
                        meta_waddr       = used_reg[PAGE_W-1:0];
                        meta_wdata.cls   = cmd_reg.cls;
                        meta_wdata.count = class_blocks(cmd_reg.cls) - 7'd1;
                        meta_wdata.lw    = class_blocks(cmd_reg.cls) - 7'd1;
                        taken_we         = 1'b1;
                        taken_waddr      = {used_reg[PAGE_W-1:0],
                                            class_blocks(cmd_reg.cls) - 7'd1};
                        taken_wdata      = 1'b1;
                        avail_we         = 1'b1;
                        avail_pg         = used_reg[PAGE_W-1:0];
                        avail_val        = class_blocks(cmd_reg.cls) != 7'd1;
                        used_next        = used_reg + 7'd1;
                        free_tot_next    = free_tot_reg
                                           + 18'(class_net_bytes(cmd_reg.cls));
                        taken_tot_next   = taken_tot_reg + 18'(a_bsz);
                        done_next        = 1'b1;
                        status_next      = ST_OK;
                        page_next        = used_reg[PAGE_W-1:0];
                        offset_next      = AREA_START
                            + (12'(class_blocks(cmd_reg.cls) - 7'd1)
                               << ({1'b0, cmd_reg.cls} + 4'd5));
                        size_next        = a_bsz;
                    end
                end
                else if ({1'b0, cmd_reg.page} >= used_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_HEAP;
                    page_next   = '0;
                    offset_next = '0;
                    size_next   = '0;
                end
                else if (cmd_reg.area_bad)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OUT_BLOCKS;
                    page_next   = '0;
                    offset_next = '0;
                    size_next   = '0;
                end
                else
                begin
                    pg_next    = cmd_reg.page;
                    meta_raddr = cmd_reg.page;
                end
            end
            S_APEEK:
            begin
                // Pop position below the low-water mark still holds its own index.
                meta_next   = meta_q;
                idx_next    = top;
                direct_next = top < meta_q.lw;
            end
            S_APOP:
            begin
                meta_we          = 1'b1;
                meta_wdata.cls   = meta_reg.cls;
                meta_wdata.count = meta_reg.count - 7'd1;
                meta_wdata.lw    = direct_reg ? idx_reg : meta_reg.lw;
                taken_we         = 1'b1;
                taken_waddr      = {pg_reg, a_idx};
                taken_wdata      = 1'b1;
                avail_we         = 1'b1;
                avail_val        = meta_reg.count != 7'd1;
                free_tot_next    = free_tot_reg - 18'(a_bsz);
                taken_tot_next   = taken_tot_reg + 18'(a_bsz);
                done_next        = 1'b1;
                status_next      = ST_OK;
                page_next        = pg_reg;
                offset_next      = AREA_START + (12'(a_idx) << ({1'b0, cmd_reg.cls} + 4'd5));
                size_next        = a_bsz;
            end
            S_FCHECK:
            begin
                meta_next = meta_q;
                idx_next  = f_idx;
                if (misaligned)
                begin
                    done_next   = 1'b1;
                    status_next = ST_INTERIOR;
                    page_next   = '0;
                    offset_next = '0;
                    size_next   = '0;
                end
                else if (f_idx >= class_blocks(f_cls))
                begin
                    done_next   = 1'b1;
                    status_next = ST_INDEX_RANGE;
                    page_next   = '0;
                    offset_next = '0;
                    size_next   = '0;
                end
            end
            S_FTAKEN:
            begin
                page_next   = '0;
                offset_next = '0;
                done_next   = 1'b1;
                if (!taken_bit)
                begin
                    status_next = ST_DOUBLE_FREE;
                    size_next   = '0;
                end
                else
                begin
                    taken_we         = 1'b1;
                    stack_we         = 1'b1;
                    meta_we          = 1'b1;
                    meta_wdata.count = meta_reg.count + 7'd1;
                    avail_we         = 1'b1;
                    avail_cls        = meta_reg.cls;
                    avail_val        = 1'b1;
                    free_tot_next    = free_tot_reg + 18'(class_bytes(meta_reg.cls));
                    taken_tot_next   = taken_tot_reg - 18'(class_bytes(meta_reg.cls));
                    status_next      = ST_OK;
                    size_next        = class_bytes(meta_reg.cls);
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            free_tot_reg  <= '0;
            taken_tot_reg <= '0;
            done_reg      <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                avail_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            free_tot_reg  <= free_tot_next;
            taken_tot_reg <= taken_tot_next;
            done_reg      <= done_next;
            if (avail_we)
            begin
                avail_reg[avail_cls][avail_pg] <= avail_val;
            end
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd;
        end
        pg_reg     <= pg_next;
        meta_reg   <= meta_next;
        idx_reg    <= idx_next;
        direct_reg <= direct_next;
        status_reg <= status_next;
        page_reg   <= page_next;
        offset_reg <= offset_next;
        size_reg   <= size_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign page_number     = page_reg;
    assign block_offset    = offset_reg;
    assign block_bytes     = size_reg;
    assign pages_in_use    = used_reg;
    assign free_bytes      = free_tot_reg;
    assign allocated_bytes = taken_tot_reg;

endmodule

@@ sv/size_class_slab_allocator.sv @@
// Top level of the size-class slab allocator: front end, queue, back end.
// Depends on scsa_pkg, scsa_front, scsa_queue and scsa_back.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Each item gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it. The back
// end works one item at a time: IDLE and DISPATCH serve an error found up
// front or a fresh-page allocate; a free caught at the alignment or index
// check adds FCHECK, an allocate from an existing page APEEK and APOP, and a
// full free FCHECK and FTAKEN. Extra states wait on registered reads of the
// page table, the per-page stack and taken bits. No clearing pass runs after
// reset: a per-page low-water mark tells which stack and taken entries are
// live. pages_in_use, free_bytes and allocated_bytes are running counters.
module size_class_slab_allocator import scsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        page_limit_we,
    input  logic [6:0]  page_limit,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [15:0] request_size,
    input  logic        is_null,
    input  logic [7:0]  free_page,
    input  logic [11:0] free_offset,
    output logic        done,
    output logic [3:0]  status,
    output logic [5:0]  page_number,
    output logic [11:0] block_offset,
    output logic [11:0] block_bytes,
    output logic [6:0]  pages_in_use,
    output logic [17:0] free_bytes,
    output logic [17:0] allocated_bytes
);

    logic [6:0] limit_reg;
    logic       push;
    logic       pop;
    logic       empty;
    logic       full;
    cmd_t       front_cmd;
    cmd_t       queue_cmd;

    // Page limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 7'd64;
        end
        else if (page_limit_we)
        begin
            limit_reg <= page_limit;
        end
    end

    assign busy = full;

    scsa_front u_front (
        .start        (start),
        .full         (full),
        .operation    (operation),
        .request_size (request_size),
        .is_null      (is_null),
        .free_page    (free_page),
        .free_offset  (free_offset),
        .push         (push),
        .cmd          (front_cmd)
    );

    scsa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (pop),
        .cmd_out (queue_cmd),
        .empty   (empty),
        .full    (full)
    );

    scsa_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .limit           (limit_reg),
        .cmd             (queue_cmd),
        .empty           (empty),
        .pop             (pop),
        .done            (done),
        .status          (status),
        .page_number     (page_number),
        .block_offset    (block_offset),
        .block_bytes     (block_bytes),
        .pages_in_use    (pages_in_use),
        .free_bytes      (free_bytes),
        .allocated_bytes (allocated_bytes)
    );

endmodule
